[sv/fresnel_pkg.sv]
// Shared constants and types for the Fresnel reflectance pipeline.
package fresnel_pkg;

	// Fraction bits of the direction and index inputs.
	localparam int FRAC_BITS = 14;
	localparam int TWO_F     = 2 * FRAC_BITS;

	// Internal fixed-point widths.
	localparam int Q30_W  = 31;     // values up to 1.0 in Q.30
	localparam int IDX_W  = 16;     // index of refraction
	localparam int ARG_W  = 61;     // square-root argument, up to 2^60
	localparam int RES_W  = 62;     // square-root working remainder
	localparam int DIV_W  = 48;     // dividend and divisor width
	localparam int DIV_N  = 30;     // quotient bits
	localparam int SQRT_N = 31;     // root bits

	localparam logic [Q30_W-1:0] Q30_ONE = Q30_W'(64'd1 << 30);
	localparam logic [15:0]      OUT_ONE = 16'd32768;

	// Side data that travels next to the iterative units.
	typedef struct packed {
		logic             tir;
		logic             zden;
		logic [IDX_W-1:0] n1;
		logic [IDX_W-1:0] n2;
		logic [Q30_W-1:0] c;
	} side_t;

endpackage

[sv/fresnel_isqrt.sv]
// Pipelined floor square root, one root bit per register stage.
module fresnel_isqrt
	import fresnel_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [ARG_W-1:0] in_arg,
	input  side_t            in_side,
	output logic             out_valid,
	output logic [Q30_W-1:0] root,
	output side_t            out_side
);

	logic [ARG_W-1:0] v_s    [0:SQRT_N];
	logic [RES_W-1:0] r_s    [0:SQRT_N];
	logic             vld_s  [0:SQRT_N];
	side_t            side_s [0:SQRT_N];

	assign v_s[0]    = in_arg;
	assign r_s[0]    = '0;
	assign vld_s[0]  = in_valid;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < SQRT_N; k++) begin : g_step
		localparam logic [RES_W-1:0] BIT = RES_W'(64'd1 << (60 - 2 * k));
		logic [RES_W-1:0] trial;
		logic             ge;

		// Try to set this root bit against the remaining argument.
		always_comb begin
			trial = r_s[k] + BIT;
			ge    = {1'b0, v_s[k]} >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				if (ge) begin
					v_s[k+1] <= v_s[k] - trial[ARG_W-1:0];
					r_s[k+1] <= (r_s[k] >> 1) + BIT;
				end else begin
					v_s[k+1] <= v_s[k];
					r_s[k+1] <= r_s[k] >> 1;
				end
			end
		end
	end

	assign out_valid = vld_s[SQRT_N];
	assign root      = r_s[SQRT_N][Q30_W-1:0];
	assign out_side  = side_s[SQRT_N];

endmodule

[sv/fresnel_div.sv]
// Pipelined restoring divider giving a Q.30 ratio, one quotient bit per stage.
module fresnel_div
	import fresnel_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [DIV_W-1:0] num,
	input  logic [DIV_W-1:0] den,
	input  side_t            in_side,
	output logic             out_valid,
	output logic [Q30_W-1:0] quot,
	output side_t            out_side
);

	logic [DIV_W-1:0] rem_s  [0:DIV_N];
	logic [DIV_W-1:0] den_s  [0:DIV_N];
	logic [DIV_N-1:0] q_s    [0:DIV_N];
	logic             zero_s [0:DIV_N];
	logic             sat_s  [0:DIV_N];
	logic             vld_s  [0:DIV_N];
	side_t            side_s [0:DIV_N];

	// A zero divisor gives zero; a ratio of one or more saturates.
	assign rem_s[0]  = num;
	assign den_s[0]  = den;
	assign q_s[0]    = '0;
	assign zero_s[0] = (den == '0);
	assign sat_s[0]  = (num >= den);
	assign vld_s[0]  = in_valid;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < DIV_N; k++) begin : g_step
		logic [DIV_W:0] shifted;
		logic           ge;

		always_comb begin
			shifted = {rem_s[k], 1'b0};
			ge      = shifted >= {1'b0, den_s[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				den_s[k+1]  <= den_s[k];
				zero_s[k+1] <= zero_s[k];
				sat_s[k+1]  <= sat_s[k];
				q_s[k+1]    <= {q_s[k][DIV_N-2:0], ge};
				if (ge) begin
					rem_s[k+1] <= DIV_W'(shifted - {1'b0, den_s[k]});
				end else begin
					rem_s[k+1] <= shifted[DIV_W-1:0];
				end
			end
		end
	end

	always_comb begin
		priority if (zero_s[DIV_N]) begin
			quot = '0;
		end else if (sat_s[DIV_N]) begin
			quot = Q30_ONE;
		end else begin
			quot = {1'b0, q_s[DIV_N]};
		end
	end

	assign out_valid = vld_s[DIV_N];
	assign out_side  = side_s[DIV_N];

endmodule

[sv/fresnel_dielectric_reflectance_top.sv]
// Top level of the unpolarized dielectric Fresnel reflectance pipeline.
//
// Input channel s_*: one transaction carries a unit surface normal, a unit
// outgoing direction (signed Q1.14 each) and the inner index of refraction
// (unsigned Q2.14). Output channel m_*: one transaction per input carries
// the reflectance in Q1.15 and a total internal reflection flag.
// The block is a single pipeline: a dot product, a square root for the
// incident sine, a Snell divider, a square root for the transmitted cosine,
// two Fresnel ratio dividers and the squaring and rounding stages. Each
// square root takes 31 stages and each divider 30. Throughput is one
// transaction per cycle unless the receiver stalls. The whole pipeline
// advances together whenever the output register is empty or being read,
// so while the receiver stalls with a result waiting, s_tready is low and
// every stage holds; no item is lost or repeated.
// Reset clears all valid bits; the block holds no other state and is ready
// for input in the first cycle after reset is released.
module fresnel_dielectric_reflectance_top
	import fresnel_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// normal_x, normal_y, normal_z, view_x, view_y, view_z, refr_index
	input  logic [111:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// reflectance[15:0], total_internal[16], zero fill
	output logic [23:0]  m_tdata
);

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// Stage 1: component products.
	logic               vld_s1;
	logic signed [31:0] px_s1, py_s1, pz_s1;
	logic [IDX_W-1:0]   n_s1;

	// Stage 2: cosine and index swap.
	logic             vld_s2;
	logic [Q30_W-1:0] c_s2;
	logic [IDX_W-1:0] n1_s2, n2_s2;

	// Stage 3: cosine squared.
	logic             vld_s3;
	logic [61:0]      cc_s3;
	side_t            side_s3;

	// Stage 4: sine times incident index.
	logic             vld_s4;
	logic [46:0]      t_s4;
	side_t            side_s4;

	// Stage 6: transmitted sine squared.
	logic             vld_s6;
	logic [61:0]      ss_s6;
	side_t            side_s6;

	// Stage 7: the four index products.
	logic             vld_s7;
	logic [46:0]      a_s7, b_s7, a2_s7, b2_s7;
	side_t            side_s7;

	// Stage 8: numerators and denominators.
	logic             vld_s8;
	logic [DIV_W-1:0] num1_s8, den1_s8, num2_s8, den2_s8;
	side_t            side_s8;

	// Stage 9: squared ratios.
	logic             vld_s9;
	logic [61:0]      r1sq_s9, r2sq_s9;
	side_t            side_s9;

	// Valid outputs of the iterative units.
	logic sq1_valid, div_valid, sq2_valid;
	logic r1_valid, r2_valid;

	logic [15:0] refl_q;
	logic        tir_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			vld_s4   <= 1'b0;
			vld_s6   <= 1'b0;
			vld_s7   <= 1'b0;
			vld_s8   <= 1'b0;
			vld_s9   <= 1'b0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			vld_s1   <= s_tvalid;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			vld_s4   <= sq1_valid;
			vld_s6   <= div_valid;
			vld_s7   <= sq2_valid;
			vld_s8   <= vld_s7;
			vld_s9   <= r1_valid;
			m_tvalid <= vld_s9;
		end
	end

	// Stage 1: multiply the components pairwise.
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= $signed(s_tdata[15:0]) * $signed(s_tdata[63:48]);
			py_s1 <= $signed(s_tdata[31:16]) * $signed(s_tdata[79:64]);
			pz_s1 <= $signed(s_tdata[47:32]) * $signed(s_tdata[95:80]);
			n_s1  <= s_tdata[111:96];
		end
	end

	// Stage 2: sum, fold the sign into an index swap, scale to Q.30.
	logic signed [33:0] dot;
	logic [63:0]        mag;
	logic [63:0]        mag_scaled;
	always_comb begin
		dot = 34'(px_s1) + 34'(py_s1) + 34'(pz_s1);
		mag = dot[33] ? 64'(-dot) : 64'(dot);
		if (TWO_F >= 30) begin
			mag_scaled = mag >> (TWO_F - 30);
		end else begin
			mag_scaled = mag << (30 - TWO_F);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (mag >= (64'd1 << TWO_F)) begin
				c_s2 <= Q30_ONE;
			end else begin
				c_s2 <= mag_scaled[Q30_W-1:0];
			end
			if (dot[33]) begin
				n1_s2 <= n_s1;
				n2_s2 <= IDX_W'(64'd1 << FRAC_BITS);
			end else begin
				n1_s2 <= IDX_W'(64'd1 << FRAC_BITS);
				n2_s2 <= n_s1;
			end
		end
	end

	// Stage 3: square the cosine.
	always_ff @(posedge clk) begin
		if (en) begin
			cc_s3        <= 62'(c_s2) * 62'(c_s2);
			side_s3.tir  <= 1'b0;
			side_s3.zden <= 1'b0;
			side_s3.n1   <= n1_s2;
			side_s3.n2   <= n2_s2;
			side_s3.c    <= c_s2;
		end
	end

	// Incident sine.
	logic [Q30_W-1:0] sin1;
	side_t            sq1_side;
	logic [ARG_W-1:0] arg1;
	assign arg1 = ARG_W'(62'd1 << 60) - cc_s3[ARG_W-1:0];

	fresnel_isqrt u_sqrt_sin1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s3),
		.in_arg   (arg1),
		.in_side  (side_s3),
		.out_valid(sq1_valid),
		.root     (sin1),
		.out_side (sq1_side)
	);

	// Stage 4: Snell numerator.
	always_ff @(posedge clk) begin
		if (en) begin
			t_s4    <= 47'(sin1) * 47'(sq1_side.n1);
			side_s4 <= sq1_side;
		end
	end

	// Total internal reflection when the Snell sine exceeds one.
	logic [DIV_W-1:0] snell_den;
	side_t            snell_side;
	always_comb begin
		snell_den      = DIV_W'(side_s4.n2) << 30;
		snell_side     = side_s4;
		snell_side.tir = DIV_W'(t_s4) > snell_den;
	end

	logic [Q30_W-1:0] sin2;
	side_t            div_side;

	fresnel_div u_div_sin2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s4),
		.num      (DIV_W'(t_s4)),
		.den      (snell_den),
		.in_side  (snell_side),
		.out_valid(div_valid),
		.quot     (sin2),
		.out_side (div_side)
	);

	// Stage 6: square the transmitted sine.
	always_ff @(posedge clk) begin
		if (en) begin
			ss_s6   <= 62'(sin2) * 62'(sin2);
			side_s6 <= div_side;
		end
	end

	logic [Q30_W-1:0] cos2;
	side_t            sq2_side;
	logic [ARG_W-1:0] arg2;
	assign arg2 = ARG_W'(62'd1 << 60) - ss_s6[ARG_W-1:0];

	fresnel_isqrt u_sqrt_cos2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s6),
		.in_arg   (arg2),
		.in_side  (side_s6),
		.out_valid(sq2_valid),
		.root     (cos2),
		.out_side (sq2_side)
	);

	// Stage 7: index times cosine products for both polarizations.
	always_ff @(posedge clk) begin
		if (en) begin
			a_s7    <= 47'(sq2_side.n1) * 47'(sq2_side.c);
			b_s7    <= 47'(sq2_side.n2) * 47'(cos2);
			a2_s7   <= 47'(sq2_side.n1) * 47'(cos2);
			b2_s7   <= 47'(sq2_side.n2) * 47'(sq2_side.c);
			side_s7 <= sq2_side;
		end
	end

	// Stage 8: absolute differences and sums.
	logic [DIV_W-1:0] den1, den2;
	side_t            side_zden;
	always_comb begin
		den1           = DIV_W'(a_s7) + DIV_W'(b_s7);
		den2           = DIV_W'(a2_s7) + DIV_W'(b2_s7);
		side_zden      = side_s7;
		side_zden.zden = (den1 == '0) || (den2 == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den1_s8 <= den1;
			den2_s8 <= den2;
			num1_s8 <= (a_s7 >= b_s7) ? DIV_W'(a_s7 - b_s7) : DIV_W'(b_s7 - a_s7);
			num2_s8 <= (a2_s7 >= b2_s7) ? DIV_W'(a2_s7 - b2_s7) : DIV_W'(b2_s7 - a2_s7);
			side_s8 <= side_zden;
		end
	end

	logic [Q30_W-1:0] r1, r2;
	side_t            r1_side, r2_side;

	fresnel_div u_div_r1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s8),
		.num      (num1_s8),
		.den      (den1_s8),
		.in_side  (side_s8),
		.out_valid(r1_valid),
		.quot     (r1),
		.out_side (r1_side)
	);

	fresnel_div u_div_r2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s8),
		.num      (num2_s8),
		.den      (den2_s8),
		.in_side  (side_s8),
		.out_valid(r2_valid),
		.quot     (r2),
		.out_side (r2_side)
	);

	// Stage 9: square the amplitude ratios.
	always_ff @(posedge clk) begin
		if (en) begin
			r1sq_s9 <= 62'(r1) * 62'(r1);
			r2sq_s9 <= 62'(r2) * 62'(r2);
			side_s9 <= r1_side;
		end
	end

	// Output register: mean of the squares, round half up, saturate.
	logic [62:0] sum;
	logic [16:0] refl;
	always_comb begin
		sum  = 63'(r1sq_s9) + 63'(r2sq_s9) + (63'd1 << 45);
		refl = sum[62:46];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (side_s9.tir) begin
				refl_q <= OUT_ONE;
				tir_q  <= 1'b1;
			end else if (side_s9.zden) begin
				refl_q <= OUT_ONE;
				tir_q  <= 1'b0;
			end else if (refl > 17'(OUT_ONE)) begin
				refl_q <= OUT_ONE;
				tir_q  <= 1'b0;
			end else begin
				refl_q <= refl[15:0];
				tir_q  <= 1'b0;
			end
		end
	end

	assign m_tdata = {7'd0, tir_q, refl_q};

	// The two ratio dividers run in lock step.
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(r1_valid == r2_valid) && (!r1_valid || r1_side == r2_side))
		else $error("ratio dividers out of step");

	// Total internal reflection always reports full reflectance.
	a_tir_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[16] |-> m_tdata[15:0] == OUT_ONE)
		else $error("TIR without full reflectance");

	// Reflectance never exceeds one.
	a_refl_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[15:0] <= OUT_ONE)
		else $error("reflectance above one");

	// The pipeline advances only when the output register can take a result.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

endmodule
